/* rtl/spg_pkg.sv */
// Shared types and constants for the step pulse generator.
package spg_pkg;

	// Timer tick rate that the step period is measured in
	localparam int TIMER_CLOCK_HZ = 1000000;

	// Field widths
	localparam int CMD_W    = 3;
	localparam int FREQ_W   = 20;
	localparam int STEPS_W  = 32;
	localparam int STAT_W   = 2;
	localparam int PERIOD_W = 16;
	localparam int CFG_IDX_W = 1;

	// Period clamp limits in timer ticks
	localparam int PERIOD_MIN = 100;
	localparam int PERIOD_MAX = 65535;

	// Dividend is TIMER_CLOCK_HZ + freq/2 for round-to-nearest
	localparam int DVD_W = $clog2(TIMER_CLOCK_HZ + (2 ** FREQ_W) / 2 + 1);
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = CFG_IDX_W'(1);

	// Reset values of the frequency limits
	localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(1);
	localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(10000);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_COUNTED = 3'd1,
		CMD_CONT    = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_SETDIR  = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_BUSY = 2'd1,
		STAT_ERR  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

endpackage

/* rtl/spg_div.sv */
// Restoring divider, one quotient bit per cycle, for the step period.
module spg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [spg_pkg::DVD_W-1:0]  dividend,
	input  logic [spg_pkg::FREQ_W-1:0] divisor,
	output logic                      done,
	output logic [spg_pkg::DVD_W-1:0]  quotient
);
	import spg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FREQ_W:0]      rem_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [FREQ_W-1:0]    dsr_q;

	logic [FREQ_W:0]      rem_sh;
	logic                 fits;

	// Shift in the next dividend bit and trial-subtract
	assign rem_sh = {rem_q[FREQ_W-1:0], dvd_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: dividend register fills with quotient bits from the right
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* rtl/step_pulse_generator.sv */
// STEP/DIR pulse generator for one stepper axis.
// Each input transaction is a timer tick or a command and yields exactly one
// result transaction. Ticks, stop, set direction, zero-count starts and rejected
// starts do not use the divider: the result is registered on the cycle after
// acceptance. A start that loads a new period runs the shared restoring divider,
// which retires one quotient bit per cycle over the 21-bit dividend; in_ready
// stays low until its result is loaded. A new transaction is taken while a
// result drains if out_ready is high in that cycle.
module step_pulse_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spg_pkg::FREQ_W-1:0]    cfg_data,
	// command input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [spg_pkg::CMD_W-1:0]     cmd,
	input  logic [spg_pkg::STEPS_W-1:0]   step_count,
	input  logic [spg_pkg::FREQ_W-1:0]    freq_hz,
	input  logic                          dir_level,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spg_pkg::STAT_W-1:0]    status,
	output logic                          busy_flag,
	output logic [spg_pkg::STEPS_W-1:0]   steps_left,
	output logic                          dir_out,
	output logic                          step_out
);
	import spg_pkg::*;

	// Configuration
	logic [FREQ_W-1:0] min_freq_q, max_freq_q;

	// Move state
	logic [STEPS_W-1:0]  remaining_q, remaining_d;
	logic                running_q, running_d;
	logic                endless_q, endless_d;
	logic                direction_q, direction_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic [PERIOD_W-1:0] tick_q, tick_d;
	logic [PERIOD_W-1:0] half_q, half_d;

	state_t state_q, state_d;

	// Pending start command held across the division
	cmd_t               pcmd_q;
	logic [STEPS_W-1:0] psteps_q;
	logic               pdir_q;

	// Output register
	logic               out_valid_q;
	status_t            status_q;
	logic               busy_q;
	logic [STEPS_W-1:0] steps_q;
	logic               dir_q;
	logic               step_q;

	logic    accept;
	logic    out_load;
	status_t status_d;
	logic    div_start;
	logic    div_done;
	logic    freq_ok;
	logic [DVD_W-1:0]    dividend;
	logic [DVD_W-1:0]    quot;
	logic [PERIOD_W-1:0] period_new;

	// Tick update values
	logic [PERIOD_W-1:0] tk_dec;
	logic [STEPS_W-1:0]  tk_rem;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign freq_ok   = (freq_hz >= min_freq_q) && (freq_hz <= max_freq_q);

	// Rounded period: (clock + f/2) / f
	assign dividend = DVD_W'(TIMER_CLOCK_HZ) + DVD_W'(freq_hz >> 1);

	spg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (freq_hz),
		.done     (div_done),
		.quotient (quot)
	);

	// Clamp the quotient to the legal period range
	always_comb begin
		if (quot > DVD_W'(PERIOD_MAX)) begin
			period_new = PERIOD_W'(PERIOD_MAX);
		end else if (quot < DVD_W'(PERIOD_MIN)) begin
			period_new = PERIOD_W'(PERIOD_MIN);
		end else begin
			period_new = quot[PERIOD_W-1:0];
		end
	end

	assign tk_dec = tick_q - 1'b1;
	assign tk_rem = (remaining_q != '0) ? (remaining_q - 1'b1) : '0;

	// Next state and result
	always_comb begin
		state_d     = state_q;
		remaining_d = remaining_q;
		running_d   = running_q;
		endless_d   = endless_q;
		direction_d = direction_q;
		period_d    = period_q;
		tick_d      = tick_q;
		half_d      = half_q;
		status_d    = STAT_OK;
		out_load    = 1'b0;
		div_start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					case (cmd_t'(cmd))
						CMD_TICK: begin
							if (running_q) begin
								if (tick_q == '0) begin
									tick_d = period_q - 1'b1;
								end else begin
									tick_d = tk_dec;
									if (tk_dec == '0 && !endless_q) begin
										remaining_d = tk_rem;
										if (tk_rem == '0) begin
											running_d = 1'b0;
											endless_d = 1'b0;
										end
									end
								end
							end
						end
						CMD_COUNTED: begin
							if (!freq_ok) begin
								status_d = STAT_ERR;
							end else if (step_count == '0) begin
								remaining_d = '0;
								running_d   = 1'b0;
								endless_d   = 1'b0;
								tick_d      = '0;
							end else if (running_q) begin
								status_d = STAT_BUSY;
							end else begin
								out_load  = 1'b0;
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						CMD_CONT: begin
							if (!freq_ok) begin
								status_d = STAT_ERR;
							end else begin
								out_load  = 1'b0;
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						CMD_STOP: begin
							remaining_d = '0;
							running_d   = 1'b0;
							endless_d   = 1'b0;
							tick_d      = '0;
						end
						CMD_SETDIR: begin
							if (running_q) begin
								status_d = STAT_BUSY;
							end else begin
								direction_d = dir_level;
							end
						end
						default: begin
							status_d = STAT_ERR;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					out_load  = 1'b1;
					state_d   = ST_IDLE;
					period_d  = period_new;
					half_d    = period_new >> 1;
					tick_d    = period_new - 1'b1;
					running_d = 1'b1;
					if (pcmd_q == CMD_CONT) begin
						direction_d = pdir_q;
						remaining_d = '1;
						endless_d   = 1'b1;
					end else begin
						remaining_d = psteps_q;
						endless_d   = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_freq_q  <= MIN_FREQ_RST;
			max_freq_q  <= MAX_FREQ_RST;
			remaining_q <= '0;
			running_q   <= 1'b0;
			endless_q   <= 1'b0;
			direction_q <= 1'b0;
			period_q    <= '0;
			tick_q      <= '0;
			half_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			remaining_q <= remaining_d;
			running_q   <= running_d;
			endless_q   <= endless_d;
			direction_q <= direction_d;
			period_q    <= period_d;
			tick_q      <= tick_d;
			half_q      <= half_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_FREQ: min_freq_q <= cfg_data;
					CFG_MAX_FREQ: max_freq_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending start fields
	always_ff @(posedge clk) begin
		if (accept) begin
			pcmd_q   <= cmd_t'(cmd);
			psteps_q <= step_count;
			pdir_q   <= dir_level;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= status_d;
			busy_q   <= running_d;
			steps_q  <= remaining_d;
			dir_q    <= direction_d;
			step_q   <= running_d && (tick_d < half_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign busy_flag  = busy_q;
	assign steps_left = steps_q;
	assign dir_out    = dir_q;
	assign step_out   = step_q;

endmodule
